// File: hdl/assert_macros.svh
// assertion macros for the triangle height rasteriser
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define THR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define THR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define THR_ASSERT(label, clk, rstn, prop)
`define THR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/thr_pkg.sv
// shared types and constants for the triangle height rasteriser
// no dependencies
package thr_pkg;
  localparam int BUF_SIDE    = 1024;
  localparam int PIX_W       = $clog2(BUF_SIDE);
  localparam int CRD_W       = 11;
  localparam int HGT_W       = 16;
  localparam int MAX_SPAN    = 8;
  localparam int QUO_W       = 16;
  localparam int Q_W         = 24;
  localparam int REM_W       = 40;

  typedef struct packed {
    logic [CRD_W-1:0] a_x;
    logic [CRD_W-1:0] a_z;
    logic [HGT_W-1:0] a_height;
    logic [CRD_W-1:0] b_x;
    logic [CRD_W-1:0] b_z;
    logic [HGT_W-1:0] b_height;
    logic [CRD_W-1:0] c_x;
    logic [CRD_W-1:0] c_z;
    logic [HGT_W-1:0] c_height;
  } tri_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_z;
    logic [15:0]      depth_value;
    logic             write_enable;
    logic             last_pixel;
    logic             span_clipped;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] pz;
    logic             we;
    logic             last;
    logic             clip;
  } tag_t;
endpackage

// File: hdl/thr_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag alongside
// depends on thr_pkg
module thr_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  thr_pkg::tag_t         tag_i,
  input  logic [thr_pkg::REM_W-1:0] rem_i,
  input  logic [thr_pkg::Q_W-1:0]   den_i,
  output logic                  valid_o,
  output thr_pkg::tag_t         tag_o,
  output logic [thr_pkg::QUO_W-1:0] quo_o
);
  import thr_pkg::*;

  logic             v_q   [QUO_W];
  tag_t             tag_q [QUO_W];
  logic [REM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int K = QUO_W - 1 - g;
    logic             v_in;
    tag_t             tag_in;
    logic [REM_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [REM_W-1:0] sh;
    logic             ge;
    if (g == 0) begin : g_first
      assign v_in   = valid_i;
      assign tag_in = tag_i;
      assign r_in   = rem_i;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = v_q[g-1];
      assign tag_in = tag_q[g-1];
      assign r_in   = rem_q[g-1];
      assign q_in   = quo_q[g-1];
    end
    assign sh = REM_W'(den_i) << K;
    assign ge = (r_in >= sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[g] <= tag_in;
      rem_q[g] <= ge ? (r_in - sh) : r_in;
      quo_q[g] <= {q_in[QUO_W-2:0], ge};
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
endmodule

// File: hdl/triangle_height_rasterizer_top.sv
// triangle height rasteriser: setup sequencer, pixel scan and interpolation pipeline
// depends on thr_pkg, thr_div and assert_macros.svh
//
// A triangle is taken when start is high and busy is low. Setup runs through
// states SET1, SET2 and SET3, then the clipped bounding box (at most 8 by 8
// pixels, x outer, z inner) is scanned at one pixel per cycle through a
// 19-stage pipeline whose depth is set by the 16-stage bit-per-stage divider.
// valid_o marks each result for one cycle and there is no back-pressure: the
// receiver must take every result in the cycle it is shown. busy stays high
// until the result with last_pixel is out (if the box lies outside the
// buffer, busy drops after setup with no results).
`include "assert_macros.svh"
module triangle_height_rasterizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  thr_pkg::tri_t tri_i,
  output logic          valid_o,
  output thr_pkg::pix_t pix_o
);
  import thr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SET1  = 3'd1;
  localparam logic [2:0] ST_SET2  = 3'd2;
  localparam logic [2:0] ST_SET3  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [CRD_W-1:0] BUF_MAX = CRD_W'(BUF_SIDE - 1);
  localparam logic [PIX_W-1:0] SPAN_M1 = PIX_W'(MAX_SPAN - 1);

  logic [2:0] state_q, state_d;
  tri_t       tri_q;

  // setup stage one
  logic [CRD_W-1:0] lox_q, hix_q, loz_q, hiz_q;
  logic signed [11:0] e1x_q, e1z_q, e2x_q, e2z_q, f2x_q, f2z_q, f3x_q, f3z_q;
  logic signed [16:0] e1h_q, e2h_q;
  // setup stage two
  logic signed [29:0] nx_q, nz_q;
  logic signed [24:0] ny_q;
  logic [PIX_W-1:0] blox_q, bhix_q, bloz_q, bhiz_q;
  logic             clip_q, empty_q;
  // setup stage three
  logic signed [41:0] ahny_q;
  logic [Q_W-1:0]     q_q;
  logic               nyneg_q, nyzero_q;

  logic [PIX_W-1:0] px_q, pz_q;

  function automatic logic [CRD_W-1:0] min3(input logic [CRD_W-1:0] p, q, r);
    logic [CRD_W-1:0] m;
    m = p;
    if (q < m) m = q;
    if (r < m) m = r;
    return m;
  endfunction

  function automatic logic [CRD_W-1:0] max3(input logic [CRD_W-1:0] p, q, r);
    logic [CRD_W-1:0] m;
    m = p;
    if (q > m) m = q;
    if (r > m) m = r;
    return m;
  endfunction

  function automatic logic signed [11:0] sdiff(input logic [CRD_W-1:0] p, q);
    return $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  logic accept, scan_last, out_last;
  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign scan_last = (state_q == ST_SCAN) && (px_q == bhix_q) && (pz_q == bhiz_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SET1;
      ST_SET1:  state_d = ST_SET2;
      ST_SET2:  state_d = ST_SET3;
      ST_SET3:  state_d = empty_q ? ST_IDLE : ST_SCAN;
      ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN: if (out_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic [CRD_W-1:0] hixc, hizc;
  assign hixc = (hix_q > BUF_MAX) ? BUF_MAX : hix_q;
  assign hizc = (hiz_q > BUF_MAX) ? BUF_MAX : hiz_q;

  logic signed [24:0] ny_abs;
  assign ny_abs = ny_q[24] ? -ny_q : ny_q;

  always_ff @(posedge clk_i) begin
    if (accept) tri_q <= tri_i;
    if (state_q == ST_SET1) begin
      lox_q <= min3(tri_q.a_x, tri_q.b_x, tri_q.c_x);
      hix_q <= max3(tri_q.a_x, tri_q.b_x, tri_q.c_x);
      loz_q <= min3(tri_q.a_z, tri_q.b_z, tri_q.c_z);
      hiz_q <= max3(tri_q.a_z, tri_q.b_z, tri_q.c_z);
      e1x_q <= sdiff(tri_q.b_x, tri_q.a_x);
      e1z_q <= sdiff(tri_q.b_z, tri_q.a_z);
      e2x_q <= sdiff(tri_q.c_x, tri_q.a_x);
      e2z_q <= sdiff(tri_q.c_z, tri_q.a_z);
      f2x_q <= sdiff(tri_q.c_x, tri_q.b_x);
      f2z_q <= sdiff(tri_q.c_z, tri_q.b_z);
      f3x_q <= sdiff(tri_q.a_x, tri_q.c_x);
      f3z_q <= sdiff(tri_q.a_z, tri_q.c_z);
      e1h_q <= $signed({1'b0, tri_q.b_height}) - $signed({1'b0, tri_q.a_height});
      e2h_q <= $signed({1'b0, tri_q.c_height}) - $signed({1'b0, tri_q.a_height});
    end
    if (state_q == ST_SET2) begin
      nx_q    <= e2z_q * e1h_q - e2h_q * e1z_q;
      ny_q    <= e2x_q * e1z_q - e2z_q * e1x_q;
      nz_q    <= e2h_q * e1x_q - e2x_q * e1h_q;
      empty_q <= (lox_q > hixc) || (loz_q > hizc);
      blox_q  <= lox_q[PIX_W-1:0];
      bloz_q  <= loz_q[PIX_W-1:0];
      bhix_q  <= (hixc - lox_q >= CRD_W'(MAX_SPAN)) ? lox_q[PIX_W-1:0] + SPAN_M1
                                                     : hixc[PIX_W-1:0];
      bhiz_q  <= (hizc - loz_q >= CRD_W'(MAX_SPAN)) ? loz_q[PIX_W-1:0] + SPAN_M1
                                                     : hizc[PIX_W-1:0];
      clip_q  <= (hixc - lox_q >= CRD_W'(MAX_SPAN)) || (hizc - loz_q >= CRD_W'(MAX_SPAN));
    end
    if (state_q == ST_SET3) begin
      ahny_q   <= $signed({1'b0, tri_q.a_height}) * ny_q;
      q_q      <= ny_abs[Q_W-1:0];
      nyneg_q  <= ny_q[24];
      nyzero_q <= (ny_q == '0);
      px_q     <= blox_q;
      pz_q     <= bloz_q;
    end else if (state_q == ST_SCAN) begin
      if (pz_q == bhiz_q) begin
        pz_q <= bloz_q;
        px_q <= px_q + PIX_W'(1);
      end else begin
        pz_q <= pz_q + PIX_W'(1);
      end
    end
  end

  // pixel pipeline: offsets, products, numerator and range check
  logic               v1_q, v2_q, v3_q;
  tag_t               t1_q, t2_q, t3_q;
  logic signed [11:0] dxa_q, dza_q, dxb_q, dzb_q, dxc_q, dzc_q;
  logic               in2_q;
  logic signed [42:0] num_q;
  logic [REM_W-1:0]   rem3_q;

  logic [CRD_W-1:0] pxw, pzw;
  assign pxw = CRD_W'(px_q);
  assign pzw = CRD_W'(pz_q);

  logic signed [24:0] s1, s2, s3;
  assign s1 = dxa_q * e1z_q - dza_q * e1x_q;
  assign s2 = dxb_q * f2z_q - dzb_q * f2x_q;
  assign s3 = f3z_q * dxc_q - f3x_q * dzc_q;

  logic signed [43:0] p, pn;
  logic               ok;
  assign p  = ahny_q - num_q;
  assign pn = nyneg_q ? -p : p;
  assign ok = in2_q && !nyzero_q && !pn[43] && (pn <= $signed({5'b0, q_q, 15'b0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_SCAN);
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= '{px: px_q, pz: pz_q, we: 1'b0, last: scan_last, clip: clip_q};
    dxa_q <= sdiff(pxw, tri_q.a_x);
    dza_q <= sdiff(pzw, tri_q.a_z);
    dxb_q <= sdiff(pxw, tri_q.b_x);
    dzb_q <= sdiff(pzw, tri_q.b_z);
    dxc_q <= sdiff(pxw, tri_q.c_x);
    dzc_q <= sdiff(pzw, tri_q.c_z);
    t2_q  <= t1_q;
    in2_q <= !s1[24] && !s2[24] && !s3[24];
    num_q <= nx_q * dxa_q + nz_q * dza_q;
    t3_q  <= '{px: t2_q.px, pz: t2_q.pz, we: ok, last: t2_q.last, clip: t2_q.clip};
    rem3_q <= ok ? pn[REM_W-1:0] : '0;
  end

  logic             dv;
  tag_t             dtag;
  logic [QUO_W-1:0] dquo;

  thr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .tag_i   (t3_q),
    .rem_i   (rem3_q),
    .den_i   (q_q),
    .valid_o (dv),
    .tag_o   (dtag),
    .quo_o   (dquo)
  );

  assign out_last = dv && dtag.last;
  assign valid_o  = dv;
  assign pix_o    = '{pixel_x: dtag.px, pixel_z: dtag.pz,
                      depth_value: dtag.we ? dquo : '0,
                      write_enable: dtag.we, last_pixel: dtag.last,
                      span_clipped: dtag.clip};

  `THR_ASSERT(a_out_busy, clk_i, rst_ni, !valid_o || busy)
  `THR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `THR_ASSERT(a_depth_range, clk_i, rst_ni, !valid_o || pix_o.depth_value <= 16'd32768)
  `THR_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, valid_o && pix_o.last_pixel, !busy)
endmodule
